// ===== rtl/ttfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ttfp_pkg
// Shared constants and types for the tagged telemetry frame parser.
// ----------------------------------------------------------------------------
package ttfp_pkg;

    // Frame delimiter and tag characters
    localparam logic [7:0] CH_START = 8'h23;  // '#'
    localparam logic [7:0] CH_END   = 8'h24;  // '$'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_B     = 8'h42;  // 'B'
    localparam logic [7:0] CH_C     = 8'h43;  // 'C'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'

    // One result transfer as produced by the parser core
    typedef struct packed {
        logic        frame_done;
        logic [31:0] long_speed;
        logic [31:0] lat_speed;
        logic [31:0] heading_rate;
        logic [7:0]  gear;
    } ttfp_result_t;

endpackage

// ===== rtl/ttfp_parser.sv =====
// ----------------------------------------------------------------------------
// ttfp_parser
// Parse state machine and stored telemetry words. Computes the result for
// the presented byte combinationally and commits the new state on step_en.
// ----------------------------------------------------------------------------
module ttfp_parser
    import ttfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    input  logic         first_in_buffer,
    output ttfp_result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_TAG  = 4'd1,
        PH_A0   = 4'd2,
        PH_A1   = 4'd3,
        PH_A2   = 4'd4,
        PH_A3   = 4'd5,
        PH_B0   = 4'd6,
        PH_B1   = 4'd7,
        PH_B2   = 4'd8,
        PH_B3   = 4'd9,
        PH_C0   = 4'd10,
        PH_C1   = 4'd11,
        PH_C2   = 4'd12,
        PH_C3   = 4'd13,
        PH_GEAR = 4'd14
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] long_speed_reg, long_speed_next;
    logic [31:0] lat_speed_reg, lat_speed_next;
    logic [31:0] heading_rate_reg, heading_rate_next;
    logic [7:0]  gear_reg, gear_next;
    logic        done;
    phase_t      cur;

    // Replace one byte lane of a word
    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  pos,
                                             input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        case (pos)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

    // Next state and stored values for the presented byte
    always_comb begin
        cur               = first_in_buffer ? PH_IDLE : phase_reg;
        phase_next        = cur;
        long_speed_next   = long_speed_reg;
        lat_speed_next    = lat_speed_reg;
        heading_rate_next = heading_rate_reg;
        gear_next         = gear_reg;
        done              = 1'b0;
        case (cur) inside
            PH_IDLE: begin
                if (rx_byte == CH_START) phase_next = PH_TAG;
            end
            PH_TAG: begin
                case (rx_byte)
                    CH_A:    phase_next = PH_A0;
                    CH_B:    phase_next = PH_B0;
                    CH_C:    phase_next = PH_C0;
                    CH_D:    phase_next = PH_GEAR;
                    default: begin
                        done       = (rx_byte == CH_END);
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            [PH_A0:PH_A3]: begin
                long_speed_next = put_byte(long_speed_reg, 2'(cur - PH_A0), rx_byte);
                phase_next      = (cur == PH_A3) ? PH_TAG : phase_t'(cur + 4'd1);
            end
            [PH_B0:PH_B3]: begin
                lat_speed_next = put_byte(lat_speed_reg, 2'(cur - PH_B0), rx_byte);
                phase_next     = (cur == PH_B3) ? PH_TAG : phase_t'(cur + 4'd1);
            end
            [PH_C0:PH_C3]: begin
                heading_rate_next = put_byte(heading_rate_reg, 2'(cur - PH_C0), rx_byte);
                phase_next        = (cur == PH_C3) ? PH_TAG : phase_t'(cur + 4'd1);
            end
            PH_GEAR: begin
                gear_next  = rx_byte;
                phase_next = PH_TAG;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign result = '{frame_done:   done,
                      long_speed:   long_speed_next,
                      lat_speed:    lat_speed_next,
                      heading_rate: heading_rate_next,
                      gear:         gear_next};

    // Commit state on each transfer into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            long_speed_reg   <= '0;
            lat_speed_reg    <= '0;
            heading_rate_reg <= '0;
            gear_reg         <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            long_speed_reg   <= long_speed_next;
            lat_speed_reg    <= lat_speed_next;
            heading_rate_reg <= heading_rate_next;
            gear_reg         <= gear_next;
        end
    end

    // A terminator always drops the parser back to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && done |=> phase_reg == PH_IDLE)
        else $error("ttfp_parser: not idle after frame end");

    // A forced idle with a non-start byte leaves the parser idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && first_in_buffer && rx_byte != CH_START |=> phase_reg == PH_IDLE)
        else $error("ttfp_parser: forced idle ignored");

    // Stored values hold while no byte is stepped
    assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(long_speed_reg) && $stable(lat_speed_reg)
                     && $stable(heading_rate_reg) && $stable(gear_reg))
        else $error("ttfp_parser: state changed without a step");

endmodule

// ===== rtl/tagged_telemetry_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tagged_telemetry_frame_parser
// Byte-wide parser for '#'-framed telemetry with A/B/C word tags and D gear tag.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result transfer carrying the frame_done
// flag and the stored words as they stand after that byte. A byte passes an
// input register, then the parse logic, then the result register, which
// offers its result; one byte per cycle is sustained while m_ready holds,
// since the parse state updates as a byte moves from the input register
// into the result register. The input register keeps accepting while a
// result waits, until both stages are full.
module tagged_telemetry_frame_parser
    import ttfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_first_in_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_done,
    output logic [31:0] m_long_speed_raw,
    output logic [31:0] m_lat_speed_raw,
    output logic [31:0] m_heading_rate_raw,
    output logic [7:0]  m_gear_value
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_first_reg;
    logic         out_valid_reg;
    ttfp_result_t out_reg;
    ttfp_result_t result;
    logic         advance;

    // Move a byte forward when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ttfp_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .rx_byte         (in_byte_reg),
        .first_in_buffer (in_first_reg),
        .result          (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_rx_byte;
            in_first_reg <= s_first_in_buffer;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_frame_done       = out_reg.frame_done;
    assign m_long_speed_raw   = out_reg.long_speed;
    assign m_lat_speed_raw    = out_reg.lat_speed;
    assign m_heading_rate_raw = out_reg.heading_rate;
    assign m_gear_value       = out_reg.gear;

    // A byte moved forward always shows up as a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("ttfp: result lost after advance");

    // A full pipeline with a stalled result takes no new byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("ttfp: accepted byte while pipeline stalled");

endmodule

// ===== tb/tagged_telemetry_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// tagged_telemetry_frame_parser_tb
// Self-checking bench for the tagged telemetry frame parser.
// ----------------------------------------------------------------------------
// A short directed table walks idle bytes, start, terminator, every tag, the
// all-ones payload bytes, unknown tags and the first-of-buffer
// resync in mid-payload. Random frames follow, mostly well formed with random
// payloads, mixed with noise, truncated frames and stray resyncs. Every
// accepted byte runs through a local parser model, and each result transfer
// is compared field by field with the oldest expected one. Both sides throttle
// at random in two profiles, then run at full rate.
// ----------------------------------------------------------------------------
module tagged_telemetry_frame_parser_tb
    import ttfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 16;

    // Parse phase encoding of the local model
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_TAG   = 4'd1;
    localparam logic [3:0] PH_LONG0 = 4'd2;
    localparam logic [3:0] PH_LAT0  = 4'd6;
    localparam logic [3:0] PH_HEAD0 = 4'd10;
    localparam logic [3:0] PH_GEAR  = 4'd14;

    localparam ttfp_result_t RESET_VALUES = '0;

    // One input byte, with an optional hand-written expectation
    typedef struct packed {
        logic [7:0]   rx;
        logic         first;
        logic         typed;
        ttfp_result_t exp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_first_in_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_done;
    logic [31:0] m_long_speed_raw;
    logic [31:0] m_lat_speed_raw;
    logic [31:0] m_heading_rate_raw;
    logic [7:0]  m_gear_value;

    stim_row_t    bus_row = '0;
    stim_row_t    byte_stream [$];
    ttfp_result_t expected_results [$];
    int           ready_idle_pct = 45;
    int           errors = 0;
    int           bytes_accepted = 0;
    int           results_checked = 0;
    int           frames_closed = 0;
    int           resyncs = 0;
    int           cycle_count = 0;

    // Local copy of the parser state
    logic [3:0]  model_phase = PH_IDLE;
    logic [31:0] model_long = '0;
    logic [31:0] model_lat = '0;
    logic [31:0] model_heading = '0;
    logic [7:0]  model_gear = '0;

    stim_row_t directed_rows [26] = '{
        '{CH_A,     1'b0, 1'b1, RESET_VALUES},
        '{CH_END,   1'b0, 1'b1, RESET_VALUES},
        '{CH_START, 1'b0, 1'b1, RESET_VALUES},
        '{CH_END,   1'b0, 1'b1, '{1'b1, 32'h0, 32'h0, 32'h0, 8'h00}},
        '{CH_START, 1'b0, 1'b0, RESET_VALUES},
        '{CH_A,     1'b0, 1'b0, RESET_VALUES},
        '{8'hFF,    1'b0, 1'b0, RESET_VALUES},
        '{8'hFF,    1'b0, 1'b0, RESET_VALUES},
        '{8'hFF,    1'b0, 1'b0, RESET_VALUES},
        '{8'hFF,    1'b0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00}},
        '{CH_D,     1'b0, 1'b0, RESET_VALUES},
        '{8'hFF,    1'b0, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'hFF}},
        '{CH_C,     1'b0, 1'b0, RESET_VALUES},
        '{8'h80,    1'b0, 1'b0, RESET_VALUES},
        '{8'h01,    1'b0, 1'b0, RESET_VALUES},
        '{CH_START, 1'b1, 1'b0, RESET_VALUES},
        '{CH_B,     1'b0, 1'b0, RESET_VALUES},
        '{8'h5A,    1'b0, 1'b0, RESET_VALUES},
        '{8'h00,    1'b1, 1'b0, RESET_VALUES},
        '{CH_START, 1'b0, 1'b0, RESET_VALUES},
        '{8'h00,    1'b0, 1'b0, RESET_VALUES},
        '{CH_END,   1'b0, 1'b0, RESET_VALUES},
        '{CH_START, 1'b0, 1'b0, RESET_VALUES},
        '{CH_END,   1'b1, 1'b0, RESET_VALUES},
        '{CH_START, 1'b1, 1'b0, RESET_VALUES},
        '{CH_END,   1'b0, 1'b0, RESET_VALUES}
    };

    tagged_telemetry_frame_parser i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .s_first_in_buffer  (s_first_in_buffer),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_done       (m_frame_done),
        .m_long_speed_raw   (m_long_speed_raw),
        .m_lat_speed_raw    (m_lat_speed_raw),
        .m_heading_rate_raw (m_heading_rate_raw),
        .m_gear_value       (m_gear_value)
    );

    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    // Advance the local parser by one byte and return the stored values
    function automatic ttfp_result_t parse_byte(input logic [7:0] rx, input logic first);
        ttfp_result_t r;
        logic [3:0]   ph;
        int           lane;
        r = '0;
        ph = first ? PH_IDLE : model_phase;
        if (ph == PH_IDLE) begin
            if (rx == CH_START) ph = PH_TAG;
        end else if (ph == PH_TAG) begin
            case (rx)
                CH_A: ph = PH_LONG0;
                CH_B: ph = PH_LAT0;
                CH_C: ph = PH_HEAD0;
                CH_D: ph = PH_GEAR;
                default: begin
                    r.frame_done = (rx == CH_END);
                    ph = PH_IDLE;
                end
            endcase
        end else if (ph < PH_LAT0) begin
            lane = ph - PH_LONG0;
            model_long[lane*8 +: 8] = rx;
            ph = (ph == PH_LAT0 - 4'd1) ? PH_TAG : ph + 4'd1;
        end else if (ph < PH_HEAD0) begin
            lane = ph - PH_LAT0;
            model_lat[lane*8 +: 8] = rx;
            ph = (ph == PH_HEAD0 - 4'd1) ? PH_TAG : ph + 4'd1;
        end else if (ph < PH_GEAR) begin
            lane = ph - PH_HEAD0;
            model_heading[lane*8 +: 8] = rx;
            ph = (ph == PH_GEAR - 4'd1) ? PH_TAG : ph + 4'd1;
        end else if (ph == PH_GEAR) begin
            model_gear = rx;
            ph = PH_TAG;
        end else begin
            ph = PH_IDLE;
        end
        model_phase = ph;
        r.long_speed   = model_long;
        r.lat_speed    = model_lat;
        r.heading_rate = model_heading;
        r.gear         = model_gear;
        return r;
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] rx, input logic first);
        stim_row_t r;
        r = '0;
        r.rx = rx;
        r.first = first;
        return r;
    endfunction

    // Payload byte, biased toward the extremes
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue one random frame, or a burst of noise
    task automatic queue_frame();
        logic [7:0] tag_chars [4] = '{CH_A, CH_B, CH_C, CH_D};
        logic [7:0] tag;
        int         segs;
        int         ending;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 6))
                byte_stream.push_back(plain_row(8'($urandom), $urandom_range(3) == 0));
            return;
        end
        byte_stream.push_back(plain_row(CH_START, $urandom_range(9) == 0));
        segs = $urandom_range(0, 6);
        for (int i = 0; i < segs; i++) begin
            tag = tag_chars[$urandom_range(3)];
            byte_stream.push_back(plain_row(tag, $urandom_range(49) == 0));
            repeat ((tag == CH_D) ? 1 : 4)
                byte_stream.push_back(plain_row(payload_byte(), $urandom_range(49) == 0));
        end
        // Close most frames; leave some with a bad tag or open
        ending = $urandom_range(9);
        if (ending < 8)
            byte_stream.push_back(plain_row(CH_END, 1'b0));
        else if (ending == 8)
            byte_stream.push_back(plain_row(8'($urandom), 1'b0));
    endtask

    // Throttle the result channel
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= ready_idle_pct);
    end

    // Predict on every byte transfer, check every result transfer
    always @(posedge aclk) begin : monitor
        ttfp_result_t predicted;
        ttfp_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = parse_byte(s_rx_byte, s_first_in_buffer);
                expected_results.push_back(bus_row.typed ? bus_row.exp : predicted);
                bytes_accepted++;
                if (s_first_in_buffer) resyncs++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no byte outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_frame_done) frames_closed++;
                    if (m_frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b", want.frame_done, m_frame_done);
                        errors++;
                    end
                    if (m_long_speed_raw !== want.long_speed) begin
                        $error("long_speed_raw: expected %h, got %h",
                               want.long_speed, m_long_speed_raw);
                        errors++;
                    end
                    if (m_lat_speed_raw !== want.lat_speed) begin
                        $error("lat_speed_raw: expected %h, got %h",
                               want.lat_speed, m_lat_speed_raw);
                        errors++;
                    end
                    if (m_heading_rate_raw !== want.heading_rate) begin
                        $error("heading_rate_raw: expected %h, got %h",
                               want.heading_rate, m_heading_rate_raw);
                        errors++;
                    end
                    if (m_gear_value !== want.gear) begin
                        $error("gear_value: expected %h, got %h", want.gear, m_gear_value);
                        errors++;
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t row;
        int        total;
        int        sent;
        int        send_idle_pct;
        logic      pending;
        foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
        while (byte_stream.size() < $size(directed_rows) + RANDOM_ITEMS) queue_frame();
        total = byte_stream.size();

        // Hold reset, then release
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Feed bytes through the three throttle profiles
        sent = 0;
        pending = 1'b0;
        send_idle_pct = 31;
        while (byte_stream.size() != 0 || pending) begin
            @(posedge aclk);
            if (pending && s_ready) pending = 1'b0;
            if (!pending) begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    row = byte_stream.pop_front();
                    s_valid <= 1'b1;
                    s_rx_byte <= row.rx;
                    s_first_in_buffer <= row.first;
                    bus_row <= row;
                    pending = 1'b1;
                    sent++;
                    if (sent == total / 3) begin
                        send_idle_pct = 45;
                        ready_idle_pct <= 31;
                    end else if (sent == 2 * total / 3) begin
                        send_idle_pct = 0;
                        ready_idle_pct <= 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
        @(posedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d bytes: %0d frames closed, %0d buffer resyncs.",
                 results_checked, bytes_accepted, frames_closed, resyncs);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
